FILE: hw/rtl/log_domain_add_approx_top_assert.svh
// Assertion macros shared by the log-add datapath.
// LDA_ASSERT_CLK checks a property on the clock and is off while reset is low.
// LDA_ASSERT_RST checks a property on the clock at every edge, reset included.
`ifndef LOG_DOMAIN_ADD_APPROX_TOP_ASSERT_SVH
`define LOG_DOMAIN_ADD_APPROX_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define LDA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LDA_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LDA_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define LDA_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/lda_pkg.sv
`default_nettype none

package lda_pkg;

  // Polynomial arithmetic runs in signed Q.28.
  localparam int POLY_FRAC = 28;
  localparam int COEF_W    = 32;
  localparam int DQ_W      = 32;
  localparam int PROD_W    = 64;

  // Segment of the difference: d <= 1.0, <= 2.5, <= 4.5, above.
  typedef enum logic [1:0] {
    SEG_LOW  = 2'd0,
    SEG_MID  = 2'd1,
    SEG_HIGH = 2'd2,
    SEG_TAIL = 2'd3
  } seg_t;

  // Side information that travels with each word down the pipeline.
  typedef struct packed {
    logic bypass;
    seg_t seg;
  } lda_ctl_t;

  // Q.28 coefficients per segment, ordered c3, c2, c1, c0.
  localparam logic signed [COEF_W-1:0] SEG_COEF [4][4] = '{
    '{ -32'sd2510095, 32'sd35073650, 32'sd133895555, 32'sd186080295 },
    '{ -32'sd3900990, 32'sd37565482, 32'sd133046148, 32'sd185795069 },
    '{ -32'sd1236154, 32'sd17026168, 32'sd186819399, 32'sd138049009 },
    '{  -32'sd123121,  32'sd2602736, 32'sd249842185,  32'sd45107133 }
  };

  // Coefficient lookup: idx 0 is the cubic term, 3 the constant term.
  function automatic logic signed [COEF_W-1:0] seg_coef(seg_t seg, logic [1:0] idx);
    logic [1:0] s;
    s = seg;
    return SEG_COEF[s][idx];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lda_in_if.sv
`default_nettype none

// Input channel: two log-domain operands per word.
interface lda_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] operand_a;
  logic signed [VALUE_WIDTH-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lda_out_if.sv
`default_nettype none

// Result channel: one log-domain sum per word.
interface lda_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] log_sum;

  modport source (output valid, output log_sum, input ready);
  modport sink   (input valid, input log_sum, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lda_front.sv
`default_nettype none

// Front end: orders the operands, forms the difference, picks the segment
// and the bypass, and scales the difference to Q.28.
module lda_front #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [1:0]                      ld_i,
  input  wire logic                            v_i,
  input  wire logic signed [VALUE_WIDTH-1:0]   operand_a_i,
  input  wire logic signed [VALUE_WIDTH-1:0]   operand_b_i,
  output logic [1:0]                           v_o,
  output logic signed [lda_pkg::COEF_W-1:0]    acc_o,
  output logic signed [lda_pkg::DQ_W-1:0]      dq_o,
  output logic [VALUE_WIDTH-1:0]               base_o,
  output lda_pkg::lda_ctl_t                    ctl_o
);

  localparam int EXT_W = 65;
  localparam logic [VALUE_WIDTH-1:0] SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [EXT_W-1:0] THRESH   = EXT_W'(15) << (FRACTION_BITS - 1);
  localparam logic [EXT_W-1:0] SEG_ONE  = EXT_W'(1) << FRACTION_BITS;
  localparam logic [EXT_W-1:0] SEG_MIDB = EXT_W'(5) << (FRACTION_BITS - 1);
  localparam logic [EXT_W-1:0] SEG_HIB  = EXT_W'(9) << (FRACTION_BITS - 1);
  localparam int SHR = (FRACTION_BITS > lda_pkg::POLY_FRAC) ?
                       FRACTION_BITS - lda_pkg::POLY_FRAC : 0;
  localparam int SHL = (FRACTION_BITS < lda_pkg::POLY_FRAC) ?
                       lda_pkg::POLY_FRAC - FRACTION_BITS : 0;

  logic [1:0]             v_r;
  logic [VALUE_WIDTH-1:0] hi_r, lo_r, d_r;
  logic [VALUE_WIDTH-1:0] hi_nxt, lo_nxt, a_u, b_u;

  logic signed [lda_pkg::COEF_W-1:0] acc_r;
  logic signed [lda_pkg::DQ_W-1:0]   dq_r;
  logic [VALUE_WIDTH-1:0]            base_r;
  lda_pkg::lda_ctl_t                 ctl_r;
  lda_pkg::lda_ctl_t                 ctl_nxt;
  logic [EXT_W-1:0]                  d_ext, d_scaled;

  // Stage one: bias to unsigned order, so log-zero becomes code zero.
  always_comb begin
    a_u = operand_a_i ^ SIGN;
    b_u = operand_b_i ^ SIGN;
    if (a_u < b_u) begin
      hi_nxt = b_u;
      lo_nxt = a_u;
    end else begin
      hi_nxt = a_u;
      lo_nxt = b_u;
    end
  end

  // Stage two: segment, bypass and Q.28 scaling of the difference.
  always_comb begin
    d_ext = EXT_W'(d_r);
    ctl_nxt.bypass = (lo_r == '0) || (d_ext >= THRESH);
    if (d_ext <= SEG_ONE) begin
      ctl_nxt.seg = lda_pkg::SEG_LOW;
    end else if (d_ext <= SEG_MIDB) begin
      ctl_nxt.seg = lda_pkg::SEG_MID;
    end else if (d_ext <= SEG_HIB) begin
      ctl_nxt.seg = lda_pkg::SEG_HIGH;
    end else begin
      ctl_nxt.seg = lda_pkg::SEG_TAIL;
    end
    d_scaled = (d_ext >> SHR) << SHL;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld_i[0]) v_r[0] <= v_i;
      if (ld_i[1]) v_r[1] <= v_r[0];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ld_i[0] && v_i) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
      d_r  <= hi_nxt - lo_nxt;
    end
    if (ld_i[1] && v_r[0]) begin
      ctl_r  <= ctl_nxt;
      base_r <= ctl_nxt.bypass ? hi_r : lo_r;
      dq_r   <= $signed(d_scaled[lda_pkg::DQ_W-1:0]);
      acc_r  <= lda_pkg::seg_coef(ctl_nxt.seg, 2'd0);
    end
  end

  assign v_o    = v_r;
  assign acc_o  = acc_r;
  assign dq_o   = dq_r;
  assign base_o = base_r;
  assign ctl_o  = ctl_r;

endmodule

`default_nettype wire

FILE: hw/rtl/lda_hstep.sv
`default_nettype none

// One Horner step: a multiply stage, then a round-and-add stage that adds
// the next coefficient of the word's segment.
module lda_hstep #(
  parameter int VALUE_WIDTH = 32,
  parameter int STEP        = 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [1:0]                      ld_i,
  input  wire logic                            v_i,
  input  wire logic signed [lda_pkg::COEF_W-1:0] acc_i,
  input  wire logic signed [lda_pkg::DQ_W-1:0] dq_i,
  input  wire logic [VALUE_WIDTH-1:0]          base_i,
  input  wire lda_pkg::lda_ctl_t               ctl_i,
  output logic [1:0]                           v_o,
  output logic signed [lda_pkg::COEF_W-1:0]    acc_o,
  output logic signed [lda_pkg::DQ_W-1:0]      dq_o,
  output logic [VALUE_WIDTH-1:0]               base_o,
  output lda_pkg::lda_ctl_t                    ctl_o
);

  localparam logic signed [lda_pkg::PROD_W-1:0] ROUND_HALF =
    lda_pkg::PROD_W'(1) <<< (lda_pkg::POLY_FRAC - 1);
  localparam logic [1:0] COEF_IDX = 2'(STEP);

  logic [1:0] v_r;

  logic signed [lda_pkg::PROD_W-1:0] prod_r, prod_nxt, biased;
  logic signed [lda_pkg::DQ_W-1:0]   dq_a_r, dq_b_r;
  logic [VALUE_WIDTH-1:0]            base_a_r, base_b_r;
  lda_pkg::lda_ctl_t                 ctl_a_r, ctl_b_r;
  logic signed [lda_pkg::COEF_W-1:0] acc_r, acc_nxt;

  // Multiply, and round the Q.56 product half up back to Q.28.
  always_comb begin
    prod_nxt = acc_i * dq_i;
    biased   = prod_r + ROUND_HALF;
    acc_nxt  = $signed(biased[lda_pkg::POLY_FRAC +: lda_pkg::COEF_W]) +
               lda_pkg::seg_coef(ctl_a_r.seg, COEF_IDX);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld_i[0]) v_r[0] <= v_i;
      if (ld_i[1]) v_r[1] <= v_r[0];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ld_i[0] && v_i) begin
      prod_r   <= prod_nxt;
      dq_a_r   <= dq_i;
      base_a_r <= base_i;
      ctl_a_r  <= ctl_i;
    end
    if (ld_i[1] && v_r[0]) begin
      acc_r    <= acc_nxt;
      dq_b_r   <= dq_a_r;
      base_b_r <= base_a_r;
      ctl_b_r  <= ctl_a_r;
    end
  end

  assign v_o    = v_r;
  assign acc_o  = acc_r;
  assign dq_o   = dq_b_r;
  assign base_o = base_b_r;
  assign ctl_o  = ctl_b_r;

endmodule

`default_nettype wire

FILE: hw/rtl/lda_back.sv
`default_nettype none

`include "log_domain_add_approx_top_assert.svh"

// Back end: clamps the polynomial at zero, converts it to the operand
// format, adds the base and saturates at the top of the range.
module lda_back #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [1:0]                        ld_i,
  input  wire logic                              v_i,
  input  wire logic signed [lda_pkg::COEF_W-1:0] acc_i,
  input  wire logic [VALUE_WIDTH-1:0]            base_i,
  input  wire lda_pkg::lda_ctl_t                 ctl_i,
  output logic [1:0]                             v_o,
  output logic signed [VALUE_WIDTH-1:0]          log_sum_o
);

  localparam int F_W   = lda_pkg::COEF_W + 4;
  localparam int SUM_W = ((VALUE_WIDTH > F_W) ? VALUE_WIDTH : F_W) + 1;
  localparam int RSH   = (FRACTION_BITS < lda_pkg::POLY_FRAC) ?
                         lda_pkg::POLY_FRAC - 1 - FRACTION_BITS : 0;
  localparam logic [F_W-1:0] RND = (FRACTION_BITS < lda_pkg::POLY_FRAC) ?
                                   (F_W'(1) << RSH) : F_W'(0);
  localparam int SHR = (FRACTION_BITS < lda_pkg::POLY_FRAC) ?
                       lda_pkg::POLY_FRAC - FRACTION_BITS : 0;
  localparam int SHL = (FRACTION_BITS > lda_pkg::POLY_FRAC) ?
                       FRACTION_BITS - lda_pkg::POLY_FRAC : 0;
  localparam logic [VALUE_WIDTH-1:0] SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [SUM_W-1:0] MASK = {{(SUM_W-VALUE_WIDTH){1'b0}}, {VALUE_WIDTH{1'b1}}};

  logic [1:0]             v_r;
  logic [F_W-1:0]         f_r, f_nxt, acc_u;
  logic [VALUE_WIDTH-1:0] base_r;
  logic                   bypass_r;
  logic [VALUE_WIDTH-1:0] log_sum_r, log_sum_nxt;
  logic [SUM_W-1:0]       sum;

  // Clamp at zero and scale to the operand format, rounding half up.
  always_comb begin
    acc_u = acc_i[lda_pkg::COEF_W-1] ? '0 : F_W'(acc_i[lda_pkg::COEF_W-2:0]);
    f_nxt = ctl_i.bypass ? '0 : (((acc_u + RND) >> SHR) << SHL);
  end

  // Add in the biased domain; saturate above the largest code.
  always_comb begin
    sum = SUM_W'(base_r) + SUM_W'(f_r);
    if (sum > MASK) begin
      log_sum_nxt = {VALUE_WIDTH{1'b1}} ^ SIGN;
    end else begin
      log_sum_nxt = sum[VALUE_WIDTH-1:0] ^ SIGN;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld_i[0]) v_r[0] <= v_i;
      if (ld_i[1]) v_r[1] <= v_r[0];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ld_i[0] && v_i) begin
      f_r      <= f_nxt;
      base_r   <= base_i;
      bypass_r <= ctl_i.bypass;
    end
    if (ld_i[1] && v_r[0]) begin
      log_sum_r <= log_sum_nxt;
    end
  end

  assign v_o       = v_r;
  assign log_sum_o = $signed(log_sum_r);

  // A bypassed word leaves with its base unchanged.
  `LDA_ASSERT_CLK(a_bypass_keeps_base, clk, rst_n, (ld_i[1] && v_r[0] && bypass_r) |=> (log_sum_r == $past(base_r ^ SIGN)), "bypassed word did not keep its base")

endmodule

`default_nettype wire

FILE: hw/rtl/log_domain_add_approx_top.sv
`default_nettype none

`include "log_domain_add_approx_top_assert.svh"

// Approximate log-add: for two signed Q.FRACTION_BITS log values returns
// log(exp(a)+exp(b)) as the smaller operand plus a piecewise cubic in the
// difference, or the larger operand when one input is the log-zero code
// (most negative value) or the difference is 7.5 or more; sums above the
// range saturate to the largest code. The block takes one word per cycle
// unless backpressure holds it; each word passes through two front-end stages,
// three Horner steps of one 32x32 multiply stage and one round-and-add stage
// each, and two back-end stages. Every stage holds only while the stage after
// it is full and stalled, so bubbles close up under backpressure and a new
// word is taken whenever any stage has room.
module log_domain_add_approx_top #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lda_in_if.sink    in_ch,
  lda_out_if.source out_ch
);

  localparam int STAGES = 10;

  logic [STAGES:0]   ld;
  logic [STAGES-1:0] v;

  logic signed [lda_pkg::COEF_W-1:0] acc_s [4];
  logic signed [lda_pkg::DQ_W-1:0]   dq_s  [3];
  logic [VALUE_WIDTH-1:0]            base_s [4];
  lda_pkg::lda_ctl_t                 ctl_s  [4];
  logic signed [VALUE_WIDTH-1:0]     log_sum;

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    ld[STAGES] = out_ch.ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  lda_front #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_i       (ld[1:0]),
    .v_i        (in_ch.valid),
    .operand_a_i(in_ch.operand_a),
    .operand_b_i(in_ch.operand_b),
    .v_o        (v[1:0]),
    .acc_o      (acc_s[0]),
    .dq_o       (dq_s[0]),
    .base_o     (base_s[0]),
    .ctl_o      (ctl_s[0])
  );

  lda_hstep #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .STEP       (1)
  ) u_hstep1 (
    .clk   (clk),
    .rst_n (rst_n),
    .ld_i  (ld[3:2]),
    .v_i   (v[1]),
    .acc_i (acc_s[0]),
    .dq_i  (dq_s[0]),
    .base_i(base_s[0]),
    .ctl_i (ctl_s[0]),
    .v_o   (v[3:2]),
    .acc_o (acc_s[1]),
    .dq_o  (dq_s[1]),
    .base_o(base_s[1]),
    .ctl_o (ctl_s[1])
  );

  lda_hstep #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .STEP       (2)
  ) u_hstep2 (
    .clk   (clk),
    .rst_n (rst_n),
    .ld_i  (ld[5:4]),
    .v_i   (v[3]),
    .acc_i (acc_s[1]),
    .dq_i  (dq_s[1]),
    .base_i(base_s[1]),
    .ctl_i (ctl_s[1]),
    .v_o   (v[5:4]),
    .acc_o (acc_s[2]),
    .dq_o  (dq_s[2]),
    .base_o(base_s[2]),
    .ctl_o (ctl_s[2])
  );

  lda_hstep #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .STEP       (3)
  ) u_hstep3 (
    .clk   (clk),
    .rst_n (rst_n),
    .ld_i  (ld[7:6]),
    .v_i   (v[5]),
    .acc_i (acc_s[2]),
    .dq_i  (dq_s[2]),
    .base_i(base_s[2]),
    .ctl_i (ctl_s[2]),
    .v_o   (v[7:6]),
    .acc_o (acc_s[3]),
    .dq_o  (),
    .base_o(base_s[3]),
    .ctl_o (ctl_s[3])
  );

  lda_back #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_i     (ld[9:8]),
    .v_i      (v[7]),
    .acc_i    (acc_s[3]),
    .base_i   (base_s[3]),
    .ctl_i    (ctl_s[3]),
    .v_o      (v[9:8]),
    .log_sum_o(log_sum)
  );

  // Channel hookup.
  assign in_ch.ready    = ld[0];
  assign out_ch.valid   = v[STAGES-1];
  assign out_ch.log_sum = log_sum;

  // The pipeline is empty right after reset.
  `LDA_ASSERT_RST(a_empty_after_reset, clk, !rst_n |=> (v == '0), "pipeline not empty after reset")
  // A word is taken whenever the output stage is free or draining.
  `LDA_ASSERT_CLK(a_ready_when_draining, clk, rst_n, (!v[STAGES-1] || out_ch.ready) |-> in_ch.ready, "input stalled while output drains")
  // When every stage is full and the output is stalled, no new word is taken.
  `LDA_ASSERT_CLK(a_full_stall_blocks, clk, rst_n, ((&v) && !out_ch.ready) |-> !in_ch.ready, "input taken while every stage is full and stalled")

endmodule

`default_nettype wire

FILE: dv/tb_log_domain_add_approx_top.sv
module tb_log_domain_add_approx_top;

  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int DQ_SHIFT      = lda_pkg::POLY_FRAC - FRACTION_BITS;

  localparam logic signed [VALUE_WIDTH-1:0] NEG_INF_CODE = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] NEG_INF_NEXT = NEG_INF_CODE + 1;
  localparam logic signed [VALUE_WIDTH-1:0] TOP_CODE     = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0]        SIGN_BIT     = NEG_INF_CODE;

  // Differences in operand format: 1.0, 2.5, 4.5 and the 7.5 cutoff.
  localparam logic [VALUE_WIDTH-1:0] GAP_ONE   = 32'd1 << FRACTION_BITS;
  localparam logic [VALUE_WIDTH-1:0] GAP_2P5   = 32'd5 << (FRACTION_BITS - 1);
  localparam logic [VALUE_WIDTH-1:0] GAP_4P5   = 32'd9 << (FRACTION_BITS - 1);
  localparam logic [VALUE_WIDTH-1:0] GAP_LIMIT = 32'd15 << (FRACTION_BITS - 1);

  // Q.28 cubic coefficients per segment, cubic term first.
  localparam longint SOFTPLUS_COEF [4][4] = '{
    '{ -64'sd2510095, 64'sd35073650, 64'sd133895555, 64'sd186080295 },
    '{ -64'sd3900990, 64'sd37565482, 64'sd133046148, 64'sd185795069 },
    '{ -64'sd1236154, 64'sd17026168, 64'sd186819399, 64'sd138049009 },
    '{  -64'sd123121,  64'sd2602736, 64'sd249842185,  64'sd45107133 }
  };

  localparam int RANDOM_WORDS     = 1130;
  localparam int N_DIRECTED       = 24;
  localparam int TOTAL_WORDS      = N_DIRECTED + RANDOM_WORDS;
  localparam int CALM_WORDS       = 150;
  localparam int LONG_HOLD_AT     = 400;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int DRAIN_AT         = 700;
  localparam int TAIL_CYCLES      = 30;
  localparam int MAX_REPORTS      = 10;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] operand_a;
    logic signed [VALUE_WIDTH-1:0] operand_b;
    logic                          fixed;
    logic signed [VALUE_WIDTH-1:0] log_sum;
  } directed_row_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] operand_a;
    logic signed [VALUE_WIDTH-1:0] operand_b;
    logic signed [VALUE_WIDTH-1:0] log_sum;
  } pending_sum_t;

  // Extremes, log-zero handling, the 7.5 cutoff and each segment boundary.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{NEG_INF_CODE,    NEG_INF_CODE,    1'b1, NEG_INF_CODE},
    '{NEG_INF_CODE,    32'sd0,          1'b1, 32'sd0},
    '{32'sd5,          NEG_INF_CODE,    1'b1, 32'sd5},
    '{TOP_CODE,        NEG_INF_CODE,    1'b1, TOP_CODE},
    '{TOP_CODE,        TOP_CODE,        1'b1, TOP_CODE},
    '{32'sd0,          32'sd0,          1'b0, 32'sd0},
    '{32'sd0,          -32'sd491520,    1'b1, 32'sd0},
    '{32'sd0,          -32'sd491519,    1'b0, 32'sd0},
    '{32'sd65536,      32'sd0,          1'b0, 32'sd0},
    '{32'sd0,          32'sd65537,      1'b0, 32'sd0},
    '{32'sd163840,     32'sd0,          1'b0, 32'sd0},
    '{32'sd0,          32'sd163841,     1'b0, 32'sd0},
    '{32'sd294912,     32'sd0,          1'b0, 32'sd0},
    '{32'sd0,          32'sd294913,     1'b0, 32'sd0},
    '{NEG_INF_NEXT,    NEG_INF_NEXT,    1'b0, 32'sd0},
    '{NEG_INF_NEXT,    NEG_INF_CODE,    1'b1, NEG_INF_NEXT},
    '{TOP_CODE,        NEG_INF_NEXT,    1'b1, TOP_CODE},
    '{NEG_INF_NEXT,    TOP_CODE,        1'b1, TOP_CODE},
    '{TOP_CODE,        TOP_CODE - 65536, 1'b0, 32'sd0},
    '{-32'sd100000,    -32'sd30000,     1'b0, 32'sd0},
    '{32'sh5555_5555,  32'sh5555_1234,  1'b0, 32'sd0},
    '{32'shAAAA_AAAA,  32'shAAAA_0F0F,  1'b0, 32'sd0},
    '{-32'sd1,         -32'sd1,         1'b0, 32'sd0},
    '{32'sd1000000,    32'sd700000,     1'b0, 32'sd0}
  };

  logic clk;
  logic rst_n;

  lda_in_if  #(.VALUE_WIDTH(VALUE_WIDTH)) in_ch ();
  lda_out_if #(.VALUE_WIDTH(VALUE_WIDTH)) out_ch ();

  log_domain_add_approx_top #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  pending_sum_t expected_sums [$];
  int           words_sent;
  int           sums_seen;
  int           sum_errors;
  logic         calm_phase;

  // Near the end both sides stop idling.
  assign calm_phase = (words_sent >= TOTAL_WORDS - CALM_WORDS);

  // Approximate log(exp(a) + exp(b)) in the block's fixed-point format.
  function automatic logic signed [VALUE_WIDTH-1:0] predict_log_sum(
    input logic [VALUE_WIDTH-1:0] a,
    input logic [VALUE_WIDTH-1:0] b
  );
    logic [VALUE_WIDTH-1:0] biased_a, biased_b, hi, lo, diff, res;
    lda_pkg::seg_t          seg;
    longint                 dq, acc, prod, total;
    int                     k;
    // Flipping the sign bit makes log-zero code 0 and keeps the order.
    biased_a = a ^ SIGN_BIT;
    biased_b = b ^ SIGN_BIT;
    if (biased_a < biased_b) begin
      hi = biased_b;
      lo = biased_a;
    end else begin
      hi = biased_a;
      lo = biased_b;
    end
    diff = hi - lo;
    if (lo == '0 || diff >= GAP_LIMIT) begin
      res = hi;
    end else begin
      if (diff <= GAP_ONE) seg = lda_pkg::SEG_LOW;
      else if (diff <= GAP_2P5) seg = lda_pkg::SEG_MID;
      else if (diff <= GAP_4P5) seg = lda_pkg::SEG_HIGH;
      else seg = lda_pkg::SEG_TAIL;
      dq = longint'({32'd0, diff}) <<< DQ_SHIFT;
      // Horner steps, each product rounded half up back to Q.28.
      acc = SOFTPLUS_COEF[int'(seg)][0];
      for (k = 1; k < 4; k++) begin
        prod = acc * dq;
        acc  = ((prod + (64'sd1 <<< (lda_pkg::POLY_FRAC - 1))) >>> lda_pkg::POLY_FRAC)
               + SOFTPLUS_COEF[int'(seg)][k];
      end
      if (acc < 0) acc = 0;
      total = longint'({32'd0, lo}) + ((acc + (64'sd1 <<< (DQ_SHIFT - 1))) >>> DQ_SHIFT);
      if (total > 64'sh0000_0000_FFFF_FFFF) res = '1;
      else res = total[VALUE_WIDTH-1:0];
    end
    return res ^ SIGN_BIT;
  endfunction

  // Offer one word, wait for it to be taken, and queue what should come out.
  task automatic send_word(
    input logic signed [VALUE_WIDTH-1:0] a,
    input logic signed [VALUE_WIDTH-1:0] b,
    input logic                          fixed,
    input logic signed [VALUE_WIDTH-1:0] fixed_sum
  );
    pending_sum_t entry;
    int           gap;
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    entry.operand_a = a;
    entry.operand_b = b;
    entry.log_sum   = fixed ? fixed_sum : predict_log_sum(a, b);
    expected_sums.push_back(entry);
    words_sent++;
    @(negedge clk);
  endtask

  // Random operand pairs, weighted toward differences below the cutoff.
  task automatic pick_operands(
    output logic signed [VALUE_WIDTH-1:0] a,
    output logic signed [VALUE_WIDTH-1:0] b
  );
    logic signed [VALUE_WIDTH-1:0] first, second;
    logic [VALUE_WIDTH-1:0]        bound;
    int                            mode;
    mode = $urandom_range(0, 99);
    if (mode < 60) begin
      first  = $urandom;
      second = first - $urandom_range(0, 500000);
    end else if (mode < 70) begin
      case ($urandom_range(0, 3))
        0:       bound = GAP_ONE;
        1:       bound = GAP_2P5;
        2:       bound = GAP_4P5;
        default: bound = GAP_LIMIT;
      endcase
      first  = $urandom;
      second = first - (bound + $urandom_range(0, 6) - 3);
    end else if (mode < 80) begin
      first  = $urandom;
      second = $urandom;
    end else if (mode < 88) begin
      first  = NEG_INF_CODE;
      second = $urandom;
    end else if (mode < 95) begin
      // Close to the top, where the sum saturates.
      first  = TOP_CODE - $urandom_range(0, 300000);
      second = first - $urandom_range(0, 300000);
    end else begin
      // Close to the bottom, log-zero included now and then.
      first  = NEG_INF_CODE + $urandom_range(0, 600000);
      second = NEG_INF_CODE + $urandom_range(0, 600000);
    end
    if ($urandom_range(0, 1) == 0) begin
      a = first;
      b = second;
    end else begin
      a = second;
      b = first;
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stimulus and the final verdict.
  initial begin
    logic signed [VALUE_WIDTH-1:0] a, b;
    int                            i;
    in_ch.valid     = 1'b0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    rst_n           = 1'b0;
    words_sent      = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      send_word(directed_rows[i].operand_a, directed_rows[i].operand_b,
                directed_rows[i].fixed, directed_rows[i].log_sum);
    end

    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i == DRAIN_AT) begin
        // Let the pipeline run dry before going on.
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_sums.size() != 0) @(negedge clk);
      end
      pick_operands(a, b);
      send_word(a, b, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (expected_sums.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sum_errors == 0 && expected_sums.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off, none near the end.
  initial begin
    int stall_left;
    bit long_hold_done;
    out_ch.ready   = 1'b0;
    stall_left     = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && words_sent >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD_CYCLES;
      end else if (stall_left == 0 && !calm_phase && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result word with the oldest pending sum.
  initial begin
    sums_seen  = 0;
    sum_errors = 0;
  end

  always @(posedge clk) begin
    pending_sum_t entry;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_sums.size() == 0) begin
        sum_errors++;
        if (sum_errors <= MAX_REPORTS) begin
          $display("result %0d: unexpected log_sum %h with nothing pending",
                   sums_seen, out_ch.log_sum);
        end
      end else begin
        entry = expected_sums.pop_front();
        if (out_ch.log_sum !== entry.log_sum) begin
          sum_errors++;
          if (sum_errors <= MAX_REPORTS) begin
            $display("result %0d: a=%h b=%h log_sum expected %h actual %h",
                     sums_seen, entry.operand_a, entry.operand_b,
                     entry.log_sum, out_ch.log_sum);
          end
        end
      end
      sums_seen++;
    end
  end

  // Run limit.
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/lda_pkg.sv
hw/rtl/lda_in_if.sv
hw/rtl/lda_out_if.sv
hw/rtl/lda_front.sv
hw/rtl/lda_hstep.sv
hw/rtl/lda_back.sv
hw/rtl/log_domain_add_approx_top.sv
dv/tb_log_domain_add_approx_top.sv
